// ===== sv/kee_pkg.sv =====
package kee_pkg;

    // Default binary point of the Q23.40 format.
    localparam int FRAC_BITS_DEF = 40;

    // Field and datapath widths.
    localparam int T_W       = 16;
    localparam int S_W       = 64;
    localparam int U_W       = 63;
    localparam int FLOOR_W   = 41;
    localparam int COEF_W    = 43;
    localparam int CFG_IDX_W = 2;
    localparam int A_W       = 59;
    localparam int DV_W      = 60;
    localparam int SQ_STEPS  = 64;
    localparam int SQ_REM_W  = 66;
    localparam int N_W       = 128;
    localparam int DIV_STEPS = 63;

    // Register reset values.
    localparam logic [FLOOR_W-1:0] TKE_FLOOR_RST = 41'd1099511628;
    localparam logic [FLOOR_W-1:0] EPS_FLOOR_RST = 41'd1099512;
    localparam logic [COEF_W-1:0]  COEF_ONE_RST  = 43'd1583296743997;
    localparam logic [COEF_W-1:0]  COEF_TWO_RST  = 43'd2111062325330;

    localparam logic signed [S_W-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [S_W-1:0] S_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TKE_FLOOR,
        CFG_EPS_FLOOR,
        CFG_COEF_ONE,
        CFG_COEF_TWO
    } kee_cfg_idx_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] tke_floor;
        logic [FLOOR_W-1:0] eps_floor;
        logic [COEF_W-1:0]  coef_one;
        logic [COEF_W-1:0]  coef_two;
    } kee_cfg_t;

    typedef struct packed {
        logic [T_W-1:0]        time_step;
        logic signed [S_W-1:0] shear_prod;
        logic signed [S_W-1:0] buoy_prod;
        logic [U_W-1:0]        energy_old;
        logic [U_W-1:0]        dissip_old;
    } kee_item_t;

    // Values that ride along the square root chain.
    typedef struct packed {
        logic [A_W-1:0]        a;
        logic signed [S_W-1:0] b;
        logic signed [S_W-1:0] ets;
        logic [T_W-1:0]        t;
        logic                  no_root;
    } kee_sq_side_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [S_W-1:0]      root;
        logic [N_W-1:0]      n;
        kee_sq_side_t        side;
    } kee_sq_t;

    // Values that ride along the divider chain.
    typedef struct packed {
        logic signed [S_W-1:0] ets;
        logic [T_W-1:0]        t;
        logic                  neg;
        logic                  ovf;
        logic                  no_root;
    } kee_dv_side_t;

    typedef struct packed {
        logic [DV_W-1:0]      rem;
        logic [DIV_STEPS-1:0] nb;
        logic [DIV_STEPS-1:0] q;
        logic [DV_W-1:0]      d;
        kee_dv_side_t         side;
    } kee_dv_t;

    // Saturating signed add.
    function automatic logic signed [S_W-1:0] sat_add(input logic signed [S_W-1:0] x,
                                                      input logic signed [S_W-1:0] y);
        logic [S_W:0] s;
        s = {x[S_W-1], x} + {y[S_W-1], y};
        if (s[S_W] != s[S_W-1])
        begin
            return s[S_W] ? S_MIN : S_MAX;
        end
        return $signed(s[S_W-1:0]);
    endfunction

    // Saturating signed subtract.
    function automatic logic signed [S_W-1:0] sat_sub(input logic signed [S_W-1:0] x,
                                                      input logic signed [S_W-1:0] y);
        logic [S_W:0] s;
        s = {x[S_W-1], x} - {y[S_W-1], y};
        if (s[S_W] != s[S_W-1])
        begin
            return s[S_W] ? S_MIN : S_MAX;
        end
        return $signed(s[S_W-1:0]);
    endfunction

    // Applies a sign to a wide magnitude and saturates to the format.
    function automatic logic signed [S_W-1:0] sat_mag(input logic neg,
                                                      input logic [N_W-1:0] m);
        logic big;
        big = (m[N_W-1:S_W-1] != '0);
        if (neg)
        begin
            return big ? S_MIN : $signed(~m[S_W-1:0] + 64'd1);
        end
        return big ? S_MAX : $signed(m[S_W-1:0]);
    endfunction

    // Magnitude of a signed value; the most negative value maps to 2^63.
    function automatic logic [S_W-1:0] abs64(input logic signed [S_W-1:0] v);
        return v[S_W-1] ? $unsigned(~v + 64'sd1) : $unsigned(v);
    endfunction

endpackage

// ===== sv/kee_in_if.sv =====
interface kee_in_if;
    logic                 valid;
    logic                 ready;
    logic [15:0]          time_step;
    logic signed [63:0]   shear_prod;
    logic signed [63:0]   buoy_prod;
    logic [62:0]          energy_old;
    logic [62:0]          dissip_old;

    modport source (output valid, output time_step, output shear_prod, output buoy_prod,
                    output energy_old, output dissip_old, input ready);
    modport sink (input valid, input time_step, input shear_prod, input buoy_prod,
                  input energy_old, input dissip_old, output ready);
endinterface

// ===== sv/kee_out_if.sv =====
interface kee_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] energy_new;
    logic [62:0] dissip_new;
    logic        no_root;

    modport source (output valid, output energy_new, output dissip_new, output no_root,
                    input ready);
    modport sink (input valid, input energy_new, input dissip_new, input no_root,
                  output ready);
endinterface

// ===== sv/k_epsilon_explicit_step_unit.sv =====
// One explicit k-epsilon time step per grid cell, Q23.40 fixed point.
// The item channel takes a time step, shear and buoyancy production and the
// old energy and dissipation; the result channel returns the new energy, the
// new dissipation and a no-root flag. A transfer happens on a clock edge with
// valid and ready both high. Configuration is a plain write port and should
// only be used while no item is in flight.
// The block is a pipeline of 139 register stages: nine for the coefficient
// arithmetic, a chain of 64 cells for the square root (one root bit per
// cell), one stage to form the numerator, a chain of 63 cells for the
// division (one quotient bit per cell) and two for the energy update. One
// item is taken every cycle while the skid entry is free.
// When the receiver stalls, a one-entry skid buffer takes the waiting result
// and the pipeline keeps moving for that cycle; while the skid entry is held
// the whole pipeline, including item ready, stops.
// Reset clears all valid bits and the skid entry and loads the configuration
// registers with their defaults; no clearing pass is needed.
module k_epsilon_explicit_step_unit #(
    parameter int FRAC_BITS = kee_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kee_in_if.sink                          item,
    kee_out_if.source                       result,
    input  logic                            cfg_write,
    input  logic [kee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kee_pkg::COEF_W-1:0]      cfg_data
);

    localparam int SQN = kee_pkg::SQ_STEPS;
    localparam int DVN = kee_pkg::DIV_STEPS;

    kee_pkg::kee_cfg_t  cfg_reg;
    kee_pkg::kee_item_t item_data;
    logic               en;

    logic [SQN:0]       sq_valid;
    kee_pkg::kee_sq_t   sq_data [SQN+1];
    logic [DVN:0]       dv_valid;
    kee_pkg::kee_dv_t   dv_data [DVN+1];

    logic               j_valid_reg;
    kee_pkg::kee_dv_t   j_data_reg;
    logic               k_valid_reg;
    logic signed [63:0] k_root_reg;
    logic [79:0]        k_tp_reg;
    logic signed [63:0] k_ets_reg;
    logic               k_noroot_reg;
    logic               l_valid_reg;
    logic [62:0]        l_energy_reg;
    logic [62:0]        l_dissip_reg;
    logic               l_noroot_reg;
    logic               skid_v_reg;
    logic [62:0]        skid_energy_reg;
    logic [62:0]        skid_dissip_reg;
    logic               skid_noroot_reg;

    logic [63:0]                r2;
    logic [63:0]                b_mag;
    logic [64:0]                num;
    logic                       num_neg;
    logic [64+FRAC_BITS:0]      num_sh;
    logic [FRAC_BITS+1:0]       num_hi;
    logic [kee_pkg::DV_W-1:0]   divisor;
    kee_pkg::kee_sq_t           sq_last;
    kee_pkg::kee_dv_t           dv_last;
    logic signed [63:0]         root;
    logic signed [63:0]         enew;
    logic signed [63:0]         tke_fl;
    logic signed [63:0]         eps_fl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tke_floor <= kee_pkg::TKE_FLOOR_RST;
            cfg_reg.eps_floor <= kee_pkg::EPS_FLOOR_RST;
            cfg_reg.coef_one  <= kee_pkg::COEF_ONE_RST;
            cfg_reg.coef_two  <= kee_pkg::COEF_TWO_RST;
        end
        else if (cfg_write)
        begin
            unique case (kee_pkg::kee_cfg_idx_t'(cfg_index))
                kee_pkg::CFG_TKE_FLOOR: cfg_reg.tke_floor <= cfg_data[kee_pkg::FLOOR_W-1:0];
                kee_pkg::CFG_EPS_FLOOR: cfg_reg.eps_floor <= cfg_data[kee_pkg::FLOOR_W-1:0];
                kee_pkg::CFG_COEF_ONE:  cfg_reg.coef_one  <= cfg_data;
                kee_pkg::CFG_COEF_TWO:  cfg_reg.coef_two  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the skid entry is free.
    assign en         = !skid_v_reg;
    assign item.ready = en;

    assign item_data.time_step  = item.time_step;
    assign item_data.shear_prod = item.shear_prod;
    assign item_data.buoy_prod  = item.buoy_prod;
    assign item_data.energy_old = item.energy_old;
    assign item_data.dissip_old = item.dissip_old;

    kee_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item.valid),
        .item       (item_data),
        .cfg        (cfg_reg),
        .out_valid  (sq_valid[0]),
        .out_data   (sq_data[0])
    );

    // Square root chain.
    for (genvar gi = 0; gi < SQN; gi++)
    begin : g_sqrt
        kee_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[gi]),
            .data_in   (sq_data[gi]),
            .valid_out (sq_valid[gi+1]),
            .data_out  (sq_data[gi+1])
        );
    end

    // Numerator of the root formula and divider seed.
    assign sq_last = sq_data[SQN];
    assign r2      = {sq_last.root[62:0], 1'b0};
    assign b_mag   = kee_pkg::abs64(sq_last.side.b);
    assign divisor = {sq_last.side.a, 1'b0};

    always_comb
    begin
        num_neg = 1'b0;
        if (sq_last.side.b[63] || (sq_last.side.b == '0))
        begin
            num = {1'b0, r2} + {1'b0, b_mag};
        end
        else if (r2 >= b_mag)
        begin
            num = {1'b0, r2 - b_mag};
        end
        else
        begin
            num     = {1'b0, b_mag - r2};
            num_neg = 1'b1;
        end
    end

    assign num_sh = {num, {FRAC_BITS{1'b0}}};
    assign num_hi = num_sh[64+FRAC_BITS:63];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j_valid_reg <= sq_valid[SQN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_data_reg.rem          <= kee_pkg::DV_W'(num_hi);
            j_data_reg.nb           <= num_sh[62:0];
            j_data_reg.q            <= '0;
            j_data_reg.d            <= divisor;
            j_data_reg.side.ets     <= sq_last.side.ets;
            j_data_reg.side.t       <= sq_last.side.t;
            j_data_reg.side.neg     <= num_neg;
            j_data_reg.side.ovf     <= (kee_pkg::DV_W'(num_hi) >= divisor);
            j_data_reg.side.no_root <= sq_last.side.no_root;
        end
    end

    assign dv_valid[0] = j_valid_reg;
    assign dv_data[0]  = j_data_reg;

    // Division chain.
    for (genvar gd = 0; gd < DVN; gd++)
    begin : g_div
        kee_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[gd]),
            .data_in   (dv_data[gd]),
            .valid_out (dv_valid[gd+1]),
            .data_out  (dv_data[gd+1])
        );
    end

    // Signed, saturated root and the energy drain product.
    assign dv_last = dv_data[DVN];

    always_comb
    begin
        if (dv_last.side.ovf)
        begin
            root = dv_last.side.neg ? kee_pkg::S_MIN : kee_pkg::S_MAX;
        end
        else if (dv_last.side.neg)
        begin
            root = $signed(~{1'b0, dv_last.q} + 64'd1);
        end
        else
        begin
            root = $signed({1'b0, dv_last.q});
        end
    end

    assign tke_fl = {23'd0, cfg_reg.tke_floor};
    assign eps_fl = {23'd0, cfg_reg.eps_floor};
    assign enew   = kee_pkg::sat_sub(k_ets_reg,
                                     kee_pkg::sat_mag(k_root_reg[63], 128'(k_tp_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k_valid_reg <= dv_valid[DVN];
            l_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_root_reg   <= root;
            k_tp_reg     <= 80'(dv_last.side.t) * 80'(kee_pkg::abs64(root));
            k_ets_reg    <= dv_last.side.ets;
            k_noroot_reg <= dv_last.side.no_root;

            // Floors, or both floors when there is no root.
            l_noroot_reg <= k_noroot_reg;
            if (k_noroot_reg)
            begin
                l_energy_reg <= {22'd0, cfg_reg.tke_floor};
                l_dissip_reg <= {22'd0, cfg_reg.eps_floor};
            end
            else
            begin
                l_energy_reg <= (enew < tke_fl) ? tke_fl[62:0] : enew[62:0];
                l_dissip_reg <= (k_root_reg < eps_fl) ? eps_fl[62:0] : k_root_reg[62:0];
            end
        end
    end

    // Skid entry for a result that the receiver does not take.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (result.ready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (l_valid_reg && !result.ready)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_energy_reg <= l_energy_reg;
            skid_dissip_reg <= l_dissip_reg;
            skid_noroot_reg <= l_noroot_reg;
        end
    end

    assign result.valid      = skid_v_reg || l_valid_reg;
    assign result.energy_new = skid_v_reg ? skid_energy_reg : l_energy_reg;
    assign result.dissip_new = skid_v_reg ? skid_dissip_reg : l_dissip_reg;
    assign result.no_root    = skid_v_reg ? skid_noroot_reg : l_noroot_reg;

    // The skid entry only fills when the receiver held off.
    ap_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(!result.ready))
        else $error("skid entry filled during a transfer");

    // Square root remainder never exceeds twice the partial root.
    ap_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[SQN] |-> (sq_last.rem <= {1'b0, sq_last.root, 1'b0}))
        else $error("square root remainder out of range");

    // Division remainder stays below the divisor unless the quotient overflowed.
    ap_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid[DVN] && !dv_last.side.ovf) |-> (dv_last.rem < dv_last.d))
        else $error("division remainder out of range");

endmodule

// ===== sv/kee_front.sv =====
module kee_front #(
    parameter int FRAC_BITS = kee_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               item_valid,
    input  kee_pkg::kee_item_t item,
    input  kee_pkg::kee_cfg_t  cfg,
    output logic               out_valid,
    output kee_pkg::kee_sq_t   out_data
);

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [8:0] valid_reg;

    // Stage A
    logic [15:0]        a_t_reg;
    logic signed [63:0] a_pr_reg;
    logic [62:0]        a_tke_reg;
    logic [62:0]        a_eps_reg;
    // Stage B
    logic [15:0]        b_t_reg;
    logic [62:0]        b_tke_reg;
    logic [62:0]        b_eps_reg;
    logic               b_prneg_reg;
    logic [79:0]        b_tp_reg;
    logic [74:0]        b_c1lo_reg;
    logic [74:0]        b_c1hi_reg;
    logic [58:0]        b_aprod_reg;
    // Stage C
    logic [15:0]        c_t_reg;
    logic [62:0]        c_eps_reg;
    logic signed [63:0] c_ets_reg;
    logic signed [63:0] c_m1_reg;
    logic [58:0]        c_a_reg;
    // Stage D
    logic [15:0]        d_t_reg;
    logic [62:0]        d_eps_reg;
    logic signed [63:0] d_ets_reg;
    logic [58:0]        d_a_reg;
    logic signed [63:0] d_dm_reg;
    // Stage E
    logic [15:0]        e_t_reg;
    logic signed [63:0] e_ets_reg;
    logic [58:0]        e_a_reg;
    logic               e_dmneg_reg;
    logic [79:0]        e_tdm_reg;
    logic [63:0]        e_pll_reg;
    logic [63:0]        e_plh_reg;
    logic [62:0]        e_phl_reg;
    logic [62:0]        e_phh_reg;
    logic               e_cneg_reg;
    // Stage F
    logic [15:0]        f_t_reg;
    logic signed [63:0] f_ets_reg;
    logic [58:0]        f_a_reg;
    logic signed [63:0] f_b_reg;
    logic signed [63:0] f_c_reg;
    // Stage G
    logic [15:0]        g_t_reg;
    logic signed [63:0] g_ets_reg;
    logic [58:0]        g_a_reg;
    logic signed [63:0] g_b_reg;
    logic               g_cle0_reg;
    logic [63:0]        g_bll_reg;
    logic [63:0]        g_blh_reg;
    logic [63:0]        g_bhh_reg;
    logic [63:0]        g_all_reg;
    logic [63:0]        g_alh_reg;
    logic [58:0]        g_ahl_reg;
    logic [58:0]        g_ahh_reg;
    // Stage H
    logic [15:0]        h_t_reg;
    logic signed [63:0] h_ets_reg;
    logic [58:0]        h_a_reg;
    logic signed [63:0] h_b_reg;
    logic               h_cle0_reg;
    logic [127:0]       h_b4_reg;
    logic [127:0]       h_ac_reg;
    // Stage I
    kee_pkg::kee_sq_t   i_data_reg;

    logic [42:0]  c3;
    logic [63:0]  pr_mag;
    logic [106:0] m1_sum;
    logic [63:0]  dm_mag;
    logic [63:0]  ets_mag;
    logic [126:0] c_sum;
    logic [63:0]  b_mag;
    logic [63:0]  c_mag;
    logic [127:0] b_sq;
    logic [127:0] ac_sum;
    logic [127:0] d4;
    logic         no_root;

    // Destruction coefficient minus one, at least one LSB.
    assign c3 = ({21'd0, cfg.coef_two} > ONE) ? (cfg.coef_two - ONE[42:0]) : 43'd1;

    assign pr_mag  = kee_pkg::abs64(a_pr_reg);
    assign m1_sum  = {b_c1hi_reg, 32'd0} + 107'(b_c1lo_reg);
    assign dm_mag  = kee_pkg::abs64(d_dm_reg);
    assign ets_mag = kee_pkg::abs64(d_ets_reg);
    assign c_sum   = 127'(e_pll_reg) + 127'({e_plh_reg, 32'd0}) + 127'({e_phl_reg, 32'd0})
                   + 127'({e_phh_reg, 64'd0});
    assign b_mag   = kee_pkg::abs64(f_b_reg);
    assign c_mag   = kee_pkg::abs64(f_c_reg);
    assign b_sq    = 128'(g_bll_reg) + 128'({g_blh_reg, 33'd0}) + {g_bhh_reg, 64'd0};
    assign ac_sum  = 128'(g_all_reg) + 128'({g_alh_reg, 32'd0}) + 128'({g_ahl_reg, 32'd0})
                   + 128'({g_ahh_reg, 64'd0});

    // Discriminant over four, or the no-root case.
    always_comb
    begin
        no_root = 1'b0;
        if (h_cle0_reg)
        begin
            d4 = h_b4_reg + h_ac_reg;
        end
        else if (h_b4_reg < h_ac_reg)
        begin
            no_root = 1'b1;
            d4      = h_b4_reg;
        end
        else
        begin
            d4 = h_b4_reg - h_ac_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[7:0], item_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Total production.
            a_t_reg   <= item.time_step;
            a_pr_reg  <= kee_pkg::sat_add(item.shear_prod, item.buoy_prod);
            a_tke_reg <= item.energy_old;
            a_eps_reg <= item.dissip_old;

            // Products of time step and c1 with the production, and of time step with c3.
            b_t_reg     <= a_t_reg;
            b_tke_reg   <= a_tke_reg;
            b_eps_reg   <= a_eps_reg;
            b_prneg_reg <= a_pr_reg[63];
            b_tp_reg    <= 80'(a_t_reg) * 80'(pr_mag);
            b_c1lo_reg  <= 75'(cfg.coef_one) * 75'(pr_mag[31:0]);
            b_c1hi_reg  <= 75'(cfg.coef_one) * 75'(pr_mag[63:32]);
            b_aprod_reg <= 59'(a_t_reg) * 59'(c3);

            // Energy before destruction and scaled production.
            c_t_reg   <= b_t_reg;
            c_eps_reg <= b_eps_reg;
            c_ets_reg <= kee_pkg::sat_add({1'b0, b_tke_reg},
                                          kee_pkg::sat_mag(b_prneg_reg, 128'(b_tp_reg)));
            c_m1_reg  <= kee_pkg::sat_mag(b_prneg_reg, 128'(m1_sum >> FRAC_BITS));
            c_a_reg   <= (b_aprod_reg == '0) ? 59'd1 : b_aprod_reg;

            d_t_reg   <= c_t_reg;
            d_eps_reg <= c_eps_reg;
            d_ets_reg <= c_ets_reg;
            d_a_reg   <= c_a_reg;
            d_dm_reg  <= kee_pkg::sat_sub({1'b0, c_eps_reg}, c_m1_reg);

            // Linear coefficient product and partial products of the constant term.
            e_t_reg     <= d_t_reg;
            e_ets_reg   <= d_ets_reg;
            e_a_reg     <= d_a_reg;
            e_dmneg_reg <= d_dm_reg[63];
            e_tdm_reg   <= 80'(d_t_reg) * 80'(dm_mag);
            e_pll_reg   <= 64'(d_eps_reg[31:0]) * 64'(ets_mag[31:0]);
            e_plh_reg   <= 64'(d_eps_reg[31:0]) * 64'(ets_mag[63:32]);
            e_phl_reg   <= 63'(d_eps_reg[62:32]) * 63'(ets_mag[31:0]);
            e_phh_reg   <= 63'(d_eps_reg[62:32]) * 63'(ets_mag[63:32]);
            e_cneg_reg  <= (d_eps_reg != '0) ^ d_ets_reg[63];

            f_t_reg   <= e_t_reg;
            f_ets_reg <= e_ets_reg;
            f_a_reg   <= e_a_reg;
            f_b_reg   <= kee_pkg::sat_add(e_ets_reg,
                                          kee_pkg::sat_mag(e_dmneg_reg, 128'(e_tdm_reg)));
            f_c_reg   <= kee_pkg::sat_mag(e_cneg_reg, 128'(c_sum >> FRAC_BITS));

            // Partial products of b*b and a*|c|.
            g_t_reg    <= f_t_reg;
            g_ets_reg  <= f_ets_reg;
            g_a_reg    <= f_a_reg;
            g_b_reg    <= f_b_reg;
            g_cle0_reg <= f_c_reg[63] || (f_c_reg == '0);
            g_bll_reg  <= 64'(b_mag[31:0]) * 64'(b_mag[31:0]);
            g_blh_reg  <= 64'(b_mag[31:0]) * 64'(b_mag[63:32]);
            g_bhh_reg  <= 64'(b_mag[63:32]) * 64'(b_mag[63:32]);
            g_all_reg  <= 64'(f_a_reg[31:0]) * 64'(c_mag[31:0]);
            g_alh_reg  <= 64'(f_a_reg[31:0]) * 64'(c_mag[63:32]);
            g_ahl_reg  <= 59'(f_a_reg[58:32]) * 59'(c_mag[31:0]);
            g_ahh_reg  <= 59'(f_a_reg[58:32]) * 59'(c_mag[63:32]);

            h_t_reg    <= g_t_reg;
            h_ets_reg  <= g_ets_reg;
            h_a_reg    <= g_a_reg;
            h_b_reg    <= g_b_reg;
            h_cle0_reg <= g_cle0_reg;
            h_b4_reg   <= b_sq >> 2;
            h_ac_reg   <= ac_sum;

            // Seed of the square root chain.
            i_data_reg.rem          <= '0;
            i_data_reg.root         <= '0;
            i_data_reg.n            <= d4;
            i_data_reg.side.a       <= h_a_reg;
            i_data_reg.side.b       <= h_b_reg;
            i_data_reg.side.ets     <= h_ets_reg;
            i_data_reg.side.t       <= h_t_reg;
            i_data_reg.side.no_root <= no_root;
        end
    end

    assign out_valid = valid_reg[8];
    assign out_data  = i_data_reg;

endmodule

// ===== sv/kee_sqrt_cell.sv =====
module kee_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  kee_pkg::kee_sq_t data_in,
    output logic             valid_out,
    output kee_pkg::kee_sq_t data_out
);

    localparam int EXT_W = kee_pkg::SQ_REM_W + 2;
    localparam int NW    = kee_pkg::N_W;

    logic             valid_reg;
    kee_pkg::kee_sq_t data_reg;
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] trial;
    logic             fit;

    // One root bit: bring down two bits and try the next odd term.
    assign ext   = {data_in.rem, data_in.n[NW-1:NW-2]};
    assign trial = EXT_W'({data_in.root, 2'b01});
    assign fit   = (ext >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg.rem  <= fit ? kee_pkg::SQ_REM_W'(ext - trial) : kee_pkg::SQ_REM_W'(ext);
            data_reg.root <= {data_in.root[kee_pkg::S_W-2:0], fit};
            data_reg.n    <= {data_in.n[NW-3:0], 2'b00};
            data_reg.side <= data_in.side;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== sv/kee_div_cell.sv =====
module kee_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  kee_pkg::kee_dv_t data_in,
    output logic             valid_out,
    output kee_pkg::kee_dv_t data_out
);

    localparam int DW = kee_pkg::DV_W;
    localparam int QW = kee_pkg::DIV_STEPS;

    logic             valid_reg;
    kee_pkg::kee_dv_t data_reg;
    logic [DW:0]      tr;
    logic             fit;

    // One quotient bit of a restoring division.
    assign tr  = {data_in.rem, data_in.nb[QW-1]};
    assign fit = (tr >= {1'b0, data_in.d});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg.rem  <= fit ? DW'(tr - {1'b0, data_in.d}) : DW'(tr);
            data_reg.nb   <= {data_in.nb[QW-2:0], 1'b0};
            data_reg.q    <= {data_in.q[QW-2:0], fit};
            data_reg.d    <= data_in.d;
            data_reg.side <= data_in.side;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
